// ===== hw/rtl/stoch_pkg.sv =====
// Shared types and constants for the stochastic oscillator.
`timescale 1ns / 1ps
`default_nettype none

package stoch_pkg;

    // port widths fixed by the bar and result formats
    localparam int PRICE_W    = 32;
    localparam int PCT_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_D_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_K_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_D_LEN = 3'd3;

    // window scan status toward the sequencer
    typedef struct packed {
        logic done;
        logic full;
    } t_win_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/stoch_bar_if.sv =====
// Input channel: one price bar per word.
`timescale 1ns / 1ps
`default_nettype none

interface stoch_bar_if;
    logic                              valid;
    logic                              ready;
    logic [stoch_pkg::PRICE_W-1:0]     close_price;
    logic [stoch_pkg::PRICE_W-1:0]     high_price;
    logic [stoch_pkg::PRICE_W-1:0]     low_price;

    modport source (output valid, output close_price, output high_price,
                    output low_price, input ready);
    modport sink   (input valid, input close_price, input high_price,
                    input low_price, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stoch_res_if.sv =====
// Output channel: one oscillator result per word.
`timescale 1ns / 1ps
`default_nettype none

interface stoch_res_if;
    logic                          valid;
    logic                          ready;
    logic [stoch_pkg::PCT_W-1:0]   k_fast_pct;
    logic [stoch_pkg::PCT_W-1:0]   d_fast_pct;
    logic [stoch_pkg::PCT_W-1:0]   k_slow_pct;
    logic [stoch_pkg::PCT_W-1:0]   d_slow_pct;
    logic                          window_full;
    logic                          flat_range;

    modport source (output valid, output k_fast_pct, output d_fast_pct,
                    output k_slow_pct, output d_slow_pct, output window_full,
                    output flat_range, input ready);
    modport sink   (input valid, input k_fast_pct, input d_fast_pct,
                    input k_slow_pct, input d_slow_pct, input window_full,
                    input flat_range, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/stoch_div.sv =====
// Shared restoring divider, one quotient bit per cycle, 15-bit quotient.
`timescale 1ns / 1ps
`default_nettype none

module stoch_div #(
    parameter int DEN_W = 32,
    parameter int NUM_W = DEN_W + stoch_pkg::PCT_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [stoch_pkg::PCT_W-1:0] o_quo
);
    localparam int QW = stoch_pkg::PCT_W;
    localparam int CW = $clog2(QW);

    // caller guarantees i_num < i_den * 2**QW, so the top part starts below i_den
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [QW-1:0]    r_low;
    logic [QW-1:0]    r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DEN_W:0]   w_trial;
    logic             w_ge;
    logic [DEN_W:0]   w_diff;

    assign w_trial = {r_rem, r_low[QW-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= i_num[NUM_W-1:QW];
                r_low  <= i_num[QW-1:0];
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low <= {r_low[QW-2:0], 1'b0};
                r_quo <= {r_quo[QW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// ===== hw/rtl/stoch_win.sv =====
// High/low ring memory and serial highest-high / lowest-low scan.
`timescale 1ns / 1ps
`default_nettype none

module stoch_win #(
    parameter int MAX_WINDOW = 64,
    parameter int PW         = 32,
    parameter int WLW        = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [PW-1:0] i_high,
    input  wire logic [PW-1:0] i_low,
    input  wire logic [WLW-1:0] i_wl,
    output stoch_pkg::t_win_stat o_stat,
    output logic [PW-1:0]      o_hh,
    output logic [PW-1:0]      o_ll
);
    localparam int AW = $clog2(MAX_WINDOW);
    localparam logic [AW-1:0] LAST = AW'(MAX_WINDOW - 1);

    typedef enum logic [0:0] {S_IDLE, S_SCAN} t_state;

    logic [2*PW-1:0] r_mem [MAX_WINDOW];
    logic [2*PW-1:0] r_rd_data;

    t_state          r_state;
    logic [AW-1:0]   r_wp;
    logic [AW-1:0]   r_rp;
    logic [WLW-1:0]  r_left;
    logic [WLW-1:0]  r_bars;
    logic            r_rd_vld;
    logic            r_done;
    logic            r_full;
    logic [PW-1:0]   r_hh;
    logic [PW-1:0]   r_ll;

    logic            w_rd_en;
    logic [WLW-1:0]  w_bars_nx;
    logic [WLW-1:0]  w_used;
    logic [PW-1:0]   w_rd_hi;
    logic [PW-1:0]   w_rd_lo;

    assign w_rd_en   = (r_state == S_SCAN) && (r_left != '0);
    assign w_bars_nx = (r_bars == WLW'(MAX_WINDOW)) ? r_bars : r_bars + 1'b1;
    assign w_used    = (w_bars_nx < i_wl) ? w_bars_nx : i_wl;
    assign w_rd_hi   = r_rd_data[2*PW-1:PW];
    assign w_rd_lo   = r_rd_data[PW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mem[r_wp] <= {i_high, i_low};
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[r_rp];
        end
    end

    // the new bar seeds the extremes; older bars are read newest first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_bars   <= '0;
            r_left   <= '0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_rd_vld <= 1'b0;
                    if (i_start) begin
                        r_wp    <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
                        r_rp    <= (r_wp == '0) ? LAST : r_wp - 1'b1;
                        r_bars  <= w_bars_nx;
                        r_left  <= w_used - 1'b1;
                        r_full  <= w_bars_nx >= i_wl;
                        r_hh    <= i_high;
                        r_ll    <= i_low;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_rd_vld <= w_rd_en;
                    if (w_rd_en) begin
                        r_rp   <= (r_rp == '0) ? LAST : r_rp - 1'b1;
                        r_left <= r_left - 1'b1;
                    end
                    if (r_rd_vld) begin
                        if (w_rd_hi > r_hh) r_hh <= w_rd_hi;
                        if (w_rd_lo < r_ll) r_ll <= w_rd_lo;
                    end
                    if (!w_rd_en && !r_rd_vld) begin
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.full = r_full;
    assign o_hh        = r_hh;
    assign o_ll        = r_ll;

endmodule

`default_nettype wire

// ===== hw/rtl/stochastic_oscillator.sv =====
// Stochastic oscillator: fast/slow %K and %D from a stream of price bars.
// One bar at a time: a new bar is accepted only in the idle state, once the previous result has
// been loaded into the output register; the serial window scan and up to four 15-step divisions
// on one divider set the pace (the %K divide is skipped for a flat range or a close at either end).
// Synchronous active-low reset clears bar count, priming and pointers; first bar primes history.
`timescale 1ns / 1ps
`default_nettype none

module stochastic_oscillator #(
    parameter int MAX_WINDOW = 64,
    parameter int MAX_SMA    = 16,
    parameter int PRICE_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    stoch_bar_if.sink   i_bar,
    stoch_res_if.source o_res,
    input  wire logic                                i_cfg_we,
    input  wire logic [stoch_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [stoch_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    localparam int PW    = (PRICE_BITS < stoch_pkg::PRICE_W) ? PRICE_BITS
                                                             : stoch_pkg::PRICE_W;
    localparam int QW    = stoch_pkg::PCT_W;
    localparam int NUM_W = PW + QW;
    localparam int WLW   = $clog2(MAX_WINDOW + 1);
    localparam int LW    = $clog2(MAX_SMA + 1);
    localparam int HAW   = $clog2(MAX_SMA);
    localparam int SUM_W = $clog2(MAX_SMA * 25600 + 1);
    localparam logic [HAW-1:0] HLAST = HAW'(MAX_SMA - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_WIN, S_PREP, S_MUL, S_KDIV, S_KWR, S_SUMK,
        S_FDDIV, S_SKDIV, S_SWR, S_SUMS, S_SDDIV, S_DONE
    } t_state;

    // configuration
    logic [6:0] r_win_len;
    logic [4:0] r_fd_len;
    logic [4:0] r_sk_len;
    logic [4:0] r_sd_len;

    logic [WLW-1:0] w_wl;
    logic [LW-1:0]  w_fd;
    logic [LW-1:0]  w_sk;
    logic [LW-1:0]  w_sd;
    logic [LW-1:0]  w_kmax;

    // sequencer
    t_state          r_state;
    logic [PW-1:0]   r_close;
    logic [PW-1:0]   r_num;
    logic [PW-1:0]   r_den;
    logic            r_flat;
    logic [QW-1:0]   r_kf;
    logic [QW-1:0]   r_df;
    logic [QW-1:0]   r_ks;
    logic [QW-1:0]   r_ds;
    logic            r_primed;
    logic [HAW-1:0]  r_hp;
    logic [HAW-1:0]  r_rp;
    logic [LW-1:0]   r_idx;
    logic [SUM_W-1:0] r_sum_d;
    logic [SUM_W-1:0] r_sum_k;
    logic            r_div_start;
    logic [NUM_W-1:0] r_div_num;
    logic [PW-1:0]   r_div_den;

    logic [QW-1:0]   r_kf_hist [MAX_SMA];
    logic [QW-1:0]   r_ks_hist [MAX_SMA];

    // output word
    logic            r_out_vld;
    logic [QW-1:0]   r_o_kf;
    logic [QW-1:0]   r_o_df;
    logic [QW-1:0]   r_o_ks;
    logic [QW-1:0]   r_o_ds;
    logic            r_o_full;
    logic            r_o_flat;

    logic                 w_accept;
    stoch_pkg::t_win_stat w_win_stat;
    logic [PW-1:0]        w_hh;
    logic [PW-1:0]        w_ll;
    logic                 w_div_done;
    logic [QW-1:0]        w_div_quo;
    logic [NUM_W-1:0]     w_prod;
    logic [QW-1:0]        w_hist_val;
    logic                 w_use_d;
    logic [SUM_W-1:0]     w_sum_d_nx;
    logic [SUM_W-1:0]     w_sum_k_nx;
    logic                 w_sum_end;
    logic                 w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len <= 7'd5;
            r_fd_len  <= 5'd3;
            r_sk_len  <= 5'd3;
            r_sd_len  <= 5'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                stoch_pkg::CFG_WINDOW_LEN: r_win_len <= i_cfg_data;
                stoch_pkg::CFG_FAST_D_LEN: r_fd_len  <= i_cfg_data[4:0];
                stoch_pkg::CFG_SLOW_K_LEN: r_sk_len  <= i_cfg_data[4:0];
                stoch_pkg::CFG_SLOW_D_LEN: r_sd_len  <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // zero acts as one, above the maximum acts as the maximum
    assign w_wl = (r_win_len == '0) ? WLW'(1) :
                  ({25'd0, r_win_len} > 32'(MAX_WINDOW)) ? WLW'(MAX_WINDOW) :
                  WLW'(r_win_len);
    assign w_fd = (r_fd_len == '0) ? LW'(1) :
                  ({27'd0, r_fd_len} > 32'(MAX_SMA)) ? LW'(MAX_SMA) : LW'(r_fd_len);
    assign w_sk = (r_sk_len == '0) ? LW'(1) :
                  ({27'd0, r_sk_len} > 32'(MAX_SMA)) ? LW'(MAX_SMA) : LW'(r_sk_len);
    assign w_sd = (r_sd_len == '0) ? LW'(1) :
                  ({27'd0, r_sd_len} > 32'(MAX_SMA)) ? LW'(MAX_SMA) : LW'(r_sd_len);
    assign w_kmax = (w_fd > w_sk) ? w_fd : w_sk;

    assign i_bar.ready = (r_state == S_IDLE);
    assign w_accept    = i_bar.valid && i_bar.ready;

    stoch_win #(
        .MAX_WINDOW (MAX_WINDOW),
        .PW         (PW),
        .WLW        (WLW)
    ) u_win (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_high  (i_bar.high_price[PW-1:0]),
        .i_low   (i_bar.low_price[PW-1:0]),
        .i_wl    (w_wl),
        .o_stat  (w_win_stat),
        .o_hh    (w_hh),
        .o_ll    (w_ll)
    );

    stoch_div #(
        .DEN_W (PW),
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_prod = {{QW{1'b0}}, r_num} * {{PW{1'b0}}, stoch_pkg::PCT_FULL};

    // history sums: fast pass feeds both means, slow pass reuses the d accumulator
    assign w_hist_val = (r_state == S_SUMS) ? r_ks_hist[r_rp] : r_kf_hist[r_rp];
    assign w_use_d    = (r_state == S_SUMS) ? (r_idx < w_sd) : (r_idx < w_fd);
    assign w_sum_d_nx = r_sum_d + (w_use_d ? SUM_W'(w_hist_val) : '0);
    assign w_sum_k_nx = r_sum_k + ((r_idx < w_sk) ? SUM_W'(w_hist_val) : '0);
    assign w_sum_end  = (r_state == S_SUMS) ? (r_idx == w_sd - 1'b1)
                                            : (r_idx == w_kmax - 1'b1);
    assign w_out_free = !r_out_vld || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (r_state == S_KWR) begin
            if (!r_primed) begin
                for (int i = 0; i < MAX_SMA; i++) r_kf_hist[i] <= r_kf;
            end else begin
                r_kf_hist[r_hp] <= r_kf;
            end
        end
        if (r_state == S_SWR) begin
            if (!r_primed) begin
                for (int i = 0; i < MAX_SMA; i++) r_ks_hist[i] <= r_ks;
            end else begin
                r_ks_hist[r_hp] <= r_ks;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_primed    <= 1'b0;
            r_hp        <= '0;
            r_div_start <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_out_vld && o_res.ready) r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_close <= i_bar.close_price[PW-1:0];
                        r_state <= S_WIN;
                    end
                end
                S_WIN: begin
                    if (w_win_stat.done) r_state <= S_PREP;
                end
                S_PREP: begin
                    r_flat <= w_hh <= w_ll;
                    r_num  <= r_close - w_ll;
                    r_den  <= w_hh - w_ll;
                    if (w_hh <= w_ll || r_close <= w_ll) begin
                        r_kf    <= '0;
                        r_state <= S_KWR;
                    end else if (r_close >= w_hh) begin
                        r_kf    <= stoch_pkg::PCT_FULL;
                        r_state <= S_KWR;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_div_num   <= w_prod;
                    r_div_den   <= r_den;
                    r_div_start <= 1'b1;
                    r_state     <= S_KDIV;
                end
                S_KDIV: begin
                    if (w_div_done) begin
                        r_kf    <= w_div_quo;
                        r_state <= S_KWR;
                    end
                end
                S_KWR: begin
                    r_idx   <= '0;
                    r_rp    <= r_hp;
                    r_sum_d <= '0;
                    r_sum_k <= '0;
                    r_state <= S_SUMK;
                end
                S_SUMK: begin
                    r_sum_d <= w_sum_d_nx;
                    r_sum_k <= w_sum_k_nx;
                    r_idx   <= r_idx + 1'b1;
                    r_rp    <= (r_rp == '0) ? HLAST : r_rp - 1'b1;
                    if (w_sum_end) begin
                        r_div_num   <= NUM_W'(w_sum_d_nx);
                        r_div_den   <= PW'(w_fd);
                        r_div_start <= 1'b1;
                        r_state     <= S_FDDIV;
                    end
                end
                S_FDDIV: begin
                    if (w_div_done) begin
                        r_df        <= w_div_quo;
                        r_div_num   <= NUM_W'(r_sum_k);
                        r_div_den   <= PW'(w_sk);
                        r_div_start <= 1'b1;
                        r_state     <= S_SKDIV;
                    end
                end
                S_SKDIV: begin
                    if (w_div_done) begin
                        r_ks    <= w_div_quo;
                        r_state <= S_SWR;
                    end
                end
                S_SWR: begin
                    r_idx   <= '0;
                    r_rp    <= r_hp;
                    r_sum_d <= '0;
                    r_state <= S_SUMS;
                end
                S_SUMS: begin
                    r_sum_d <= w_sum_d_nx;
                    r_idx   <= r_idx + 1'b1;
                    r_rp    <= (r_rp == '0) ? HLAST : r_rp - 1'b1;
                    if (w_sum_end) begin
                        r_div_num   <= NUM_W'(w_sum_d_nx);
                        r_div_den   <= PW'(w_sd);
                        r_div_start <= 1'b1;
                        r_state     <= S_SDDIV;
                    end
                end
                S_SDDIV: begin
                    if (w_div_done) begin
                        r_ds    <= w_div_quo;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_vld <= 1'b1;
                        r_o_kf    <= r_kf;
                        r_o_df    <= r_df;
                        r_o_ks    <= r_ks;
                        r_o_ds    <= r_ds;
                        r_o_full  <= w_win_stat.full;
                        r_o_flat  <= r_flat;
                        r_primed  <= 1'b1;
                        r_hp      <= (r_hp == HLAST) ? '0 : r_hp + 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.k_fast_pct  = r_o_kf;
    assign o_res.d_fast_pct  = r_o_df;
    assign o_res.k_slow_pct  = r_o_ks;
    assign o_res.d_slow_pct  = r_o_ds;
    assign o_res.window_full = r_o_full;
    assign o_res.flat_range  = r_o_flat;

endmodule

`default_nettype wire

// ===== verif/tb_stochastic_oscillator.sv =====
// Self-checking testbench for the stochastic oscillator: price bars in, %K/%D words out.
`timescale 1ns / 1ps

module tb_stochastic_oscillator;

    localparam int PRICE_W       = stoch_pkg::PRICE_W;
    localparam int PCT_W         = stoch_pkg::PCT_W;
    localparam int CFG_IDX_W     = stoch_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = stoch_pkg::CFG_DATA_W;
    localparam int MAX_WIN       = 64;
    localparam int MAX_AVG       = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 200;
    localparam int STALL_LIMIT   = 20000;
    localparam int MAX_PRINTED   = 50;

    typedef struct packed {
        logic [PCT_W-1:0] k_fast;
        logic [PCT_W-1:0] d_fast;
        logic [PCT_W-1:0] k_slow;
        logic [PCT_W-1:0] d_slow;
        logic             full;
        logic             flat;
    } t_osc_word;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    stoch_bar_if bar_ch ();
    stoch_res_if res_ch ();

    stochastic_oscillator #(
        .MAX_WINDOW (MAX_WIN),
        .MAX_SMA    (MAX_AVG),
        .PRICE_BITS (PRICE_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_bar      (bar_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // oscillator state as the block should hold it
    logic [PRICE_W-1:0] high_ring [MAX_WIN];
    logic [PRICE_W-1:0] low_ring [MAX_WIN];
    logic [PCT_W-1:0]   kfast_ring [MAX_AVG];
    logic [PCT_W-1:0]   kslow_ring [MAX_AVG];
    int unsigned        bar_count;
    int unsigned        win_ptr;
    int unsigned        hist_ptr;
    bit                 primed;
    logic [6:0]         win_len_cfg;
    logic [4:0]         fd_len_cfg;
    logic [4:0]         sk_len_cfg;
    logic [4:0]         sd_len_cfg;

    t_osc_word   expected_osc [$];
    t_osc_word   seen_osc;
    t_osc_word   want_osc;
    int unsigned mismatches;
    int unsigned words_checked;
    int unsigned bars_sent;
    int unsigned settings_applied;
    int unsigned quiet_cycles;
    int unsigned res_hold_req;
    bit          calm;
    bit          bar_on;
    logic [PRICE_W-1:0] walk_price = 32'h4000_0000;

    function automatic int unsigned eff_len(input int unsigned v, input int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // mean of the newest len entries, newest just below hist_ptr
    function automatic logic [PCT_W-1:0] hist_mean(input bit slow_ring, input int unsigned len);
        logic [31:0] sum;
        int unsigned idx;
        sum = '0;
        for (int unsigned i = 0; i < len; i++) begin
            idx = (hist_ptr + MAX_AVG - 1 - i) % MAX_AVG;
            sum += slow_ring ? kslow_ring[idx] : kfast_ring[idx];
        end
        return PCT_W'(sum / len);
    endfunction

    function automatic t_osc_word compute_oscillator(input logic [PRICE_W-1:0] close_p,
                                                     input logic [PRICE_W-1:0] high_p,
                                                     input logic [PRICE_W-1:0] low_p);
        t_osc_word r;
        int unsigned wl, used, idx, saved;
        logic [PRICE_W-1:0] hh, ll;
        logic [63:0] kf;
        high_ring[win_ptr] = high_p;
        low_ring[win_ptr]  = low_p;
        win_ptr = (win_ptr + 1) % MAX_WIN;
        if (bar_count < MAX_WIN) bar_count++;
        wl   = eff_len(win_len_cfg, MAX_WIN);
        used = (bar_count < wl) ? bar_count : wl;
        idx  = (win_ptr + MAX_WIN - 1) % MAX_WIN;
        hh   = high_ring[idx];
        ll   = low_ring[idx];
        for (int unsigned i = 1; i < used; i++) begin
            idx = (win_ptr + MAX_WIN - 1 - i) % MAX_WIN;
            if (high_ring[idx] > hh) hh = high_ring[idx];
            if (low_ring[idx] < ll) ll = low_ring[idx];
        end
        r.flat = (hh <= ll);
        if (r.flat || close_p <= ll) kf = '0;
        else if (close_p >= hh) kf = 64'(stoch_pkg::PCT_FULL);
        else kf = (64'(close_p - ll) * 64'(stoch_pkg::PCT_FULL)) / 64'(hh - ll);
        r.k_fast = kf[PCT_W-1:0];
        // first bar after reset fills both histories
        if (!primed) begin
            for (int i = 0; i < MAX_AVG; i++) kfast_ring[i] = r.k_fast;
        end else begin
            kfast_ring[hist_ptr] = r.k_fast;
        end
        saved    = hist_ptr;
        hist_ptr = (hist_ptr + 1) % MAX_AVG;
        r.d_fast = hist_mean(1'b0, eff_len(fd_len_cfg, MAX_AVG));
        r.k_slow = hist_mean(1'b0, eff_len(sk_len_cfg, MAX_AVG));
        if (!primed) begin
            for (int i = 0; i < MAX_AVG; i++) kslow_ring[i] = r.k_slow;
        end else begin
            kslow_ring[saved] = r.k_slow;
        end
        r.d_slow = hist_mean(1'b1, eff_len(sd_len_cfg, MAX_AVG));
        primed = 1'b1;
        r.full = (bar_count >= wl);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (mismatches < MAX_PRINTED)
            $display("mismatch at output word %0d: %s = %0d, expected %0d",
                     words_checked, what, got, want);
        mismatches++;
    endtask

    // checks output words, tracks register writes, predicts each accepted bar
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            bar_count   = 0;
            win_ptr     = 0;
            hist_ptr    = 0;
            primed      = 1'b0;
            win_len_cfg = 7'd5;
            fd_len_cfg  = 5'd3;
            sk_len_cfg  = 5'd3;
            sd_len_cfg  = 5'd3;
            expected_osc.delete();
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                seen_osc.k_fast = res_ch.k_fast_pct;
                seen_osc.d_fast = res_ch.d_fast_pct;
                seen_osc.k_slow = res_ch.k_slow_pct;
                seen_osc.d_slow = res_ch.d_slow_pct;
                seen_osc.full   = res_ch.window_full;
                seen_osc.flat   = res_ch.flat_range;
                if (expected_osc.size() == 0) begin
                    report_mismatch("pending words", 0, 1);
                end else begin
                    want_osc = expected_osc.pop_front();
                    if (seen_osc.k_fast !== want_osc.k_fast)
                        report_mismatch("k_fast_pct", seen_osc.k_fast, want_osc.k_fast);
                    if (seen_osc.d_fast !== want_osc.d_fast)
                        report_mismatch("d_fast_pct", seen_osc.d_fast, want_osc.d_fast);
                    if (seen_osc.k_slow !== want_osc.k_slow)
                        report_mismatch("k_slow_pct", seen_osc.k_slow, want_osc.k_slow);
                    if (seen_osc.d_slow !== want_osc.d_slow)
                        report_mismatch("d_slow_pct", seen_osc.d_slow, want_osc.d_slow);
                    if (seen_osc.full !== want_osc.full)
                        report_mismatch("window_full", seen_osc.full, want_osc.full);
                    if (seen_osc.flat !== want_osc.flat)
                        report_mismatch("flat_range", seen_osc.flat, want_osc.flat);
                end
                words_checked++;
            end
            if (cfg_we) begin
                case (cfg_idx)
                    stoch_pkg::CFG_WINDOW_LEN: win_len_cfg = cfg_data[6:0];
                    stoch_pkg::CFG_FAST_D_LEN: fd_len_cfg  = cfg_data[4:0];
                    stoch_pkg::CFG_SLOW_K_LEN: sk_len_cfg  = cfg_data[4:0];
                    stoch_pkg::CFG_SLOW_D_LEN: sd_len_cfg  = cfg_data[4:0];
                    default: ;
                endcase
            end
            if (bar_ch.valid && bar_ch.ready)
                expected_osc.push_back(compute_oscillator(bar_ch.close_price,
                                                          bar_ch.high_price,
                                                          bar_ch.low_price));
        end
    end

    always @(posedge i_clk) begin
        if ((bar_ch.valid && bar_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off on request
    initial begin
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_hold_req != 0) begin
                res_ch.ready <= 1'b0;
                repeat (res_hold_req) @(posedge i_clk);
                res_hold_req = 0;
            end else begin
                res_ch.ready <= calm || ($urandom_range(0, 99) >= 28);
            end
        end
    end

    task automatic send_bar(input logic [PRICE_W-1:0] c, input logic [PRICE_W-1:0] h,
                            input logic [PRICE_W-1:0] l);
        bar_ch.valid       <= 1'b1;
        bar_ch.close_price <= c;
        bar_ch.high_price  <= h;
        bar_ch.low_price   <= l;
        bar_on = 1'b1;
        do @(posedge i_clk); while (!bar_ch.ready);
        bars_sent++;
        if (!calm && $urandom_range(0, 99) < 28) begin
            bar_ch.valid       <= 1'b0;
            bar_ch.close_price <= $urandom;
            bar_ch.high_price  <= $urandom;
            bar_ch.low_price   <= $urandom;
            bar_on = 1'b0;
            repeat ($urandom_range(1, 180)) @(posedge i_clk);
        end
    endtask

    function automatic logic [PRICE_W-1:0] boundary_price();
        case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return PRICE_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // mostly a random walk of sane bars, some raw noise and boundary values
    task automatic send_random_bars(input int unsigned count);
        logic [PRICE_W-1:0] c, h, l, spread;
        logic [PRICE_W:0]   top;
        logic [63:0]        span;
        int unsigned        pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                c = $urandom;
                h = $urandom;
                l = $urandom;
            end else if (pick < 14) begin
                c = boundary_price();
                h = boundary_price();
                l = boundary_price();
            end else begin
                if ($urandom_range(0, 99) == 0) walk_price = $urandom;
                spread = $urandom >> $urandom_range(4, 31);
                walk_price = $urandom_range(0, 1) ? walk_price + (spread >> 1)
                                                  : walk_price - (spread >> 1);
                top = {1'b0, walk_price} + spread;
                h = top[PRICE_W] ? '1 : top[PRICE_W-1:0];
                l = (walk_price >= spread) ? walk_price - spread : '0;
                span = 64'(h) - 64'(l) + 64'd1;
                c = l + PRICE_W'(64'($urandom) % span);
                if ($urandom_range(0, 99) < 10) c = $urandom;
            end
            send_bar(c, h, l);
        end
    endtask

    task automatic wait_idle();
        if (bar_on) begin
            bar_ch.valid <= 1'b0;
            bar_on = 1'b0;
        end
        do @(posedge i_clk); while (expected_osc.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // writes all four lengths plus one write to an unused index
    task automatic write_lengths(input logic [CFG_DATA_W-1:0] win,
                                 input logic [CFG_DATA_W-1:0] fd,
                                 input logic [CFG_DATA_W-1:0] sk,
                                 input logic [CFG_DATA_W-1:0] sd);
        logic [CFG_IDX_W-1:0]  idx_list [5];
        logic [CFG_DATA_W-1:0] data_list [5];
        wait_idle();
        idx_list[0]  = stoch_pkg::CFG_WINDOW_LEN;
        idx_list[1]  = stoch_pkg::CFG_FAST_D_LEN;
        idx_list[2]  = stoch_pkg::CFG_SLOW_K_LEN;
        idx_list[3]  = stoch_pkg::CFG_SLOW_D_LEN;
        idx_list[4]  = CFG_IDX_W'(stoch_pkg::CFG_SLOW_D_LEN + 1 + $urandom_range(0, 3));
        data_list[0] = win;
        data_list[1] = fd;
        data_list[2] = sk;
        data_list[3] = sd;
        data_list[4] = CFG_DATA_W'($urandom);
        for (int i = 0; i < 5; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= idx_list[i];
            cfg_data <= data_list[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        settings_applied++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] avg_len_setting();
        return $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(1, 16))
                                    : CFG_DATA_W'($urandom_range(0, 127));
    endfunction

    // reset lengths: priming by the first bar, window filling, close at the range ends
    task automatic test_priming_and_fill();
        send_bar(32'd600, 32'd1000, 32'd500);
        send_bar(32'd0, 32'hFFFF_FFFF, 32'd0);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'd12345, 32'd20000, 32'd10000);
        send_bar(32'd5, 32'd3000, 32'd100);
        send_bar(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
        send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    // one-bar window: flat, inverted, and close below / above / inside the range
    task automatic test_flat_range();
        write_lengths(7'd1, 7'd1, 7'd16, 7'd2);
        send_bar(32'd7, 32'd7, 32'd7);
        send_bar(32'd9, 32'd100, 32'd100);
        send_bar(32'd50, 32'd40, 32'd60);
        send_bar(32'd10, 32'd200, 32'd20);
        send_bar(32'd300, 32'd200, 32'd20);
        send_bar(32'd100, 32'd200, 32'd20);
        send_bar(32'd0, 32'd0, 32'd0);
    endtask

    // zero lengths act as one, oversize lengths clamp, upper data bits masked
    task automatic test_length_limits();
        write_lengths(7'd0, 7'd0, 7'd17, 7'h7F);
        send_random_bars(6);
        write_lengths(7'd100, 7'h40, 7'h21, 7'd16);
        send_random_bars(6);
    endtask

    task automatic test_setting_extremes();
        logic [CFG_DATA_W-1:0] sweep [4][4];
        sweep = '{'{7'd1, 7'd1, 7'd1, 7'd1}, '{7'd64, 7'd16, 7'd16, 7'd16},
                  '{7'd127, 7'd31, 7'd31, 7'd31}, '{7'd2, 7'd5, 7'd9, 7'd13}};
        for (int i = 0; i < 4; i++) begin
            write_lengths(sweep[i][0], sweep[i][1], sweep[i][2], sweep[i][3]);
            send_random_bars(sweep[i][0] >= MAX_WIN ? 70 : 30);
        end
    endtask

    // result side held off while bars keep coming, so the input stalls
    task automatic test_backpressure();
        write_lengths(7'd5, 7'd3, 7'd3, 7'd3);
        res_hold_req = 1500;
        calm = 1'b1;
        send_random_bars(20);
        calm = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_phases();
        logic [CFG_DATA_W-1:0] win;
        int unsigned pick;
        for (int p = 0; p < 12; p++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) win = CFG_DATA_W'($urandom_range(1, 12));
            else if (pick < 85) win = CFG_DATA_W'($urandom_range(13, 64));
            else win = CFG_DATA_W'($urandom_range(0, 127));
            write_lengths(win, avg_len_setting(), avg_len_setting(), avg_len_setting());
            calm = (p == 5);
            send_random_bars(100);
            calm = 1'b0;
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_idx             <= '0;
        cfg_data            <= '0;
        bar_ch.valid        <= 1'b0;
        bar_ch.close_price  <= '0;
        bar_ch.high_price   <= '0;
        bar_ch.low_price    <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_priming_and_fill();
        test_flat_range();
        test_length_limits();
        test_setting_extremes();
        test_backpressure();
        test_random_phases();

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_osc.size() != 0)
            report_mismatch("pending words at end", expected_osc.size(), 0);
        $display("Checked %0d oscillator words from %0d bars over %0d length settings.",
                 words_checked, bars_sent, settings_applied);
        $display("Windows of 1 to 64 bars, clamped lengths, flat ranges, stalls: %0d mismatches.",
                 mismatches);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
